### design/cbfa_pkg.sv
// Package with the constants, codes and word types of the contiguous block fit allocator.
`default_nettype none
package cbfa_pkg;

	localparam int NUM_BLOCKS = 32;
	localparam int SIZE_BITS = 16;
	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	localparam int AMOUNT_W = 16;
	localparam int LOAD_INDEX_W = 5;
	localparam int BLOCK_INDEX_W = 5;
	localparam int REMAIN_W = 16;
	localparam int CMP_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

	localparam int POLICY_W = 2;
	localparam int BLOCK_COUNT_W = 6;
	localparam int CFG_DATA_W = 6;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_FIT_POLICY = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

	localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POLICY_BEST = 2'd1;
	localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic [1:0] ST_LOADED = 2'd0;
	localparam logic [1:0] ST_ALLOCATED = 2'd1;
	localparam logic [1:0] ST_NOFIT = 2'd2;

	localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RESET = 6'd32;

	typedef struct packed {
		logic                    opcode;
		logic [LOAD_INDEX_W-1:0] load_index;
		logic [AMOUNT_W-1:0]     amount;
	} req_word_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [BLOCK_INDEX_W-1:0] block_index;
		logic [REMAIN_W-1:0]      remaining_size;
	} rsp_word_t;

endpackage
`default_nettype wire

### design/contiguous_block_fit_allocator.sv
// Top level of the contiguous block fit allocator: free size table, scan sequencer and result register.
//
// The block holds a table of free sizes, one entry per memory block, cleared to zero at reset.
// Request words arrive on req with req_valid; a word is taken when req_valid is high and
// req_stall is low. A load word writes one entry; an allocate word scans the first block_count
// entries through one shared compare unit, one entry per cycle, picks a block under the
// configured fit policy and subtracts the request from it.
// Each request word gives exactly one response word on rsp, taken when rsp_valid is high and
// rsp_stall is low. A load word passes through the load state and the result register before its
// response enters the response register, and the next word is taken once the block is idle.
// An allocate word passes through the scan, update and result states; the scan covers the first
// block_count entries, limited to 32, and first fit stops early at the first entry that fits.
// One word is worked on at a time, so req_stall is high until the result has
// entered the response register; that register lets the next word be taken while a
// response still waits. A stalled response holds its value and, once the next result is ready,
// the block waits for it to be taken. Reset clears the table, the sequencer and the valid flag
// of the response register, and sets first fit with 32 blocks. The user must write configuration
// through cfg_we, cfg_index and cfg_data only while the block is idle; the block does not enforce it.
`default_nettype none
module contiguous_block_fit_allocator
	import cbfa_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   req_valid,
	output logic                        req_stall,
	input  wire req_word_t              req,
	output logic                        rsp_valid,
	input  wire logic                   rsp_stall,
	output rsp_word_t                   rsp
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_UPDATE = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	logic [2:0]               state_q;
	logic [POLICY_W-1:0]      fit_policy_q;
	logic [BLOCK_COUNT_W-1:0] block_count_q;
	logic [SIZE_BITS-1:0]     table_q [NUM_BLOCKS];

	logic                     opcode_q;
	logic [LOAD_INDEX_W-1:0]  load_index_q;
	logic [AMOUNT_W-1:0]      amount_q;
	logic [CNT_W-1:0]         scan_cnt_q;
	logic [CNT_W-1:0]         limit_q;
	logic                     found_q;
	logic [IDX_W-1:0]         pick_q;
	logic [SIZE_BITS-1:0]     pick_val_q;
	rsp_word_t                res_q;
	logic                     rsp_valid_q;
	rsp_word_t                rsp_q;

	logic [SIZE_BITS-1:0]     entry;
	logic                     fits;
	logic                     better;
	logic                     take;
	logic                     first_mode;
	logic                     load_in_range;
	logic                     tbl_we;
	logic [IDX_W-1:0]         tbl_addr;
	logic [SIZE_BITS-1:0]     tbl_wdata;
	logic [SIZE_BITS-1:0]     new_size;
	logic                     rsp_free;
	logic [CNT_W-1:0]         limit_next;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	assign entry = table_q[scan_cnt_q[IDX_W-1:0]];
	assign fits = CMP_W'(entry) >= CMP_W'(amount_q);
	assign first_mode = (fit_policy_q != POLICY_BEST) && (fit_policy_q != POLICY_WORST);

	always_comb begin
		case (fit_policy_q)
			POLICY_BEST: better = entry < pick_val_q;
			POLICY_WORST: better = entry > pick_val_q;
			default: better = 1'b0;
		endcase
	end

	assign take = fits && (!found_q || better);
	assign load_in_range = 32'(load_index_q) < NUM_BLOCKS;
	assign new_size = pick_val_q - SIZE_BITS'(amount_q);
	assign limit_next = (32'(block_count_q) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
		: CNT_W'(block_count_q);

	always_comb begin
		tbl_we = 1'b0;
		tbl_addr = pick_q;
		tbl_wdata = new_size;
		if (state_q == S_LOAD) begin
			tbl_we = load_in_range;
			tbl_addr = IDX_W'(load_index_q);
			tbl_wdata = SIZE_BITS'(amount_q);
		end else if (state_q == S_UPDATE) begin
			tbl_we = found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				table_q[i] <= '0;
			end
		end else if (tbl_we) begin
			table_q[tbl_addr] <= tbl_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q <= POLICY_FIRST;
			block_count_q <= BLOCK_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIT_POLICY: fit_policy_q <= cfg_data[POLICY_W-1:0];
				CFG_BLOCK_COUNT: block_count_q <= cfg_data[BLOCK_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
			found_q <= 1'b0;
			scan_cnt_q <= '0;
		end else begin
			if (state_q == S_RESULT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						found_q <= 1'b0;
						scan_cnt_q <= '0;
						state_q <= (req.opcode == OP_LOAD) ? S_LOAD : S_SCAN;
					end
				end
				S_LOAD: begin
					state_q <= S_RESULT;
				end
				S_SCAN: begin
					if (scan_cnt_q == limit_q) begin
						state_q <= S_UPDATE;
					end else begin
						scan_cnt_q <= scan_cnt_q + CNT_W'(1);
						if (take) begin
							found_q <= 1'b1;
							if (first_mode) begin
								state_q <= S_UPDATE;
							end
						end
					end
				end
				S_UPDATE: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					opcode_q <= req.opcode;
					load_index_q <= req.load_index;
					amount_q <= req.amount;
					limit_q <= limit_next;
				end
			end
			S_LOAD: begin
				res_q.status <= ST_LOADED;
				res_q.block_index <= load_index_q;
				res_q.remaining_size <= load_in_range ? REMAIN_W'(SIZE_BITS'(amount_q)) : '0;
			end
			S_SCAN: begin
				if (scan_cnt_q != limit_q && take) begin
					pick_q <= scan_cnt_q[IDX_W-1:0];
					pick_val_q <= entry;
				end
			end
			S_UPDATE: begin
				if (found_q && opcode_q == OP_ALLOC) begin
					res_q.status <= ST_ALLOCATED;
					res_q.block_index <= BLOCK_INDEX_W'(pick_q);
					res_q.remaining_size <= REMAIN_W'(new_size);
				end else begin
					res_q.status <= ST_NOFIT;
					res_q.block_index <= '0;
					res_q.remaining_size <= '0;
				end
			end
			S_RESULT: begin
				if (rsp_free) begin
					rsp_q <= res_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
